@@ src/tcw_pkg.sv @@
package tcw_pkg;

  // Grid geometry
  localparam int COLUMNS   = 100;
  localparam int ROWS      = 30;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int CUR_W     = $clog2(COLUMNS + 1);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Control bytes
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  localparam logic [7:0]  BLANK_CHAR = 8'h20;
  localparam logic [23:0] WHITE      = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [23:0] color;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [23:0] cell_color;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;
    logic init_step;
    logic clear_step;
    logic scroll_step;
    logic exec_commit;
    logic read_commit;
    logic fin_commit;
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic is_clear;
    logic need_scroll;
    logic row_end;
    logic all_end;
  } tcw_status_t;

  // Visible row to physical row through the ring offset
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] vis,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, vis} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

endpackage

@@ src/tcw_ram.sv @@
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tcw_dp.sv @@
module tcw_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcw_pkg::in_item_t    in_data,
  input  tcw_pkg::tcw_cmd_t    cmd,
  output tcw_pkg::tcw_status_t status,
  output tcw_pkg::out_item_t   out_data
);
  import tcw_pkg::*;

  in_item_t         item_r;
  out_item_t        out_r, out_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [CUR_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_line_r, cur_line_nxt;
  logic [ROW_W-1:0] srow_r, srow_nxt;
  logic [COL_W-1:0] scol_r, scol_nxt;

  logic              is_put, is_read, is_clear;
  logic              code_nl, code_cr, code_bs, code_tab, printable;
  logic [CUR_W:0]    tab_sum, tab_col;
  logic              tab_wrap, row_full, wrap, at_bottom, need_scroll;
  logic [ROW_W-1:0]  line_inc, top_inc, put_vis, put_prow, rd_prow;
  logic [COL_W-1:0]  put_col;
  logic              rd_in_range;
  logic              sweep_step, row_end, all_end;

  logic              we_char, we_color;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wchar, rchar;
  logic [23:0]       wcolor, rcolor;

  // Cell memories: characters and colours apart, so a clear keeps colours
  tcw_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_chars (
    .clk   (clk),
    .we    (we_char),
    .waddr (waddr),
    .wdata (wchar),
    .raddr (raddr),
    .rdata (rchar)
  );

  tcw_ram #(.WIDTH(24), .DEPTH(MEM_DEPTH)) u_colors (
    .clk   (clk),
    .we    (we_color),
    .waddr (waddr),
    .wdata (wcolor),
    .raddr (raddr),
    .rdata (rcolor)
  );

  // Item decode
  assign is_put    = (item_r.action == ACT_PUT);
  assign is_read   = (item_r.action == ACT_READ);
  assign is_clear  = (item_r.action == ACT_CLEAR);
  assign code_nl   = (item_r.char_code == CH_NL);
  assign code_cr   = (item_r.char_code == CH_CR);
  assign code_bs   = (item_r.char_code == CH_BS);
  assign code_tab  = (item_r.char_code == CH_TAB);
  assign printable = !(code_nl || code_cr || code_bs || code_tab);

  // Tab stop and wrap conditions
  assign tab_sum     = {1'b0, cur_col_r} + (CUR_W+1)'(8);
  assign tab_col     = tab_sum & ~((CUR_W+1)'(7));
  assign tab_wrap    = (tab_col >= (CUR_W+1)'(COLUMNS));
  assign row_full    = (cur_col_r >= CUR_W'(COLUMNS));
  assign wrap        = code_nl || (code_tab && tab_wrap) || (printable && row_full);
  assign at_bottom   = (cur_line_r == ROW_W'(ROWS - 1));
  assign need_scroll = is_put && wrap && at_bottom;

  assign line_inc = cur_line_r + ROW_W'(1);
  assign top_inc  = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);

  // Cell addresses: physical row above column, column pitch a power of two
  assign put_vis  = row_full ? line_inc : cur_line_r;
  assign put_col  = row_full ? '0 : COL_W'(cur_col_r);
  assign put_prow = phys_row(put_vis, top_r);
  assign rd_prow  = phys_row(ROW_W'(item_r.read_row), top_r);
  assign raddr    = {rd_prow, COL_W'(item_r.read_col)};
  assign rd_in_range = (int'(item_r.read_row) < ROWS) && (int'(item_r.read_col) < COLUMNS);

  // Sweep counter status
  assign sweep_step = cmd.init_step || cmd.clear_step || cmd.scroll_step;
  assign row_end    = (scol_r == COL_W'(COLUMNS - 1));
  assign all_end    = row_end && (srow_r == ROW_W'(ROWS - 1));

  assign status.is_read     = is_read;
  assign status.is_clear    = is_clear;
  assign status.need_scroll = need_scroll;
  assign status.row_end     = row_end;
  assign status.all_end     = all_end;

  // Cursor, ring offset and memory writes
  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_line_nxt = cur_line_r;
    top_nxt      = top_r;
    we_char      = 1'b0;
    we_color     = 1'b0;
    waddr        = {srow_r, scol_r};
    wchar        = BLANK_CHAR;
    wcolor       = WHITE;

    if (cmd.init_step) begin
      we_char  = 1'b1;
      we_color = 1'b1;
    end
    if (cmd.clear_step) begin
      we_char = 1'b1;
    end
    if (cmd.scroll_step) begin
      we_char  = 1'b1;
      we_color = 1'b1;
      waddr    = {top_r, scol_r};
    end

    // Put that needs no scroll
    if (cmd.exec_commit && is_put) begin
      if (code_nl || (code_tab && tab_wrap)) begin
        cur_col_nxt  = '0;
        cur_line_nxt = line_inc;
      end else if (code_cr) begin
        cur_col_nxt = '0;
      end else if (code_bs) begin
        if (cur_col_r != '0) begin
          cur_col_nxt = cur_col_r - CUR_W'(1);
        end
      end else if (code_tab) begin
        cur_col_nxt = CUR_W'(tab_col);
      end else begin
        we_char  = 1'b1;
        we_color = 1'b1;
        waddr    = {put_prow, put_col};
        wchar    = item_r.char_code;
        wcolor   = item_r.color;
        if (row_full) begin
          cur_line_nxt = line_inc;
          cur_col_nxt  = CUR_W'(1);
        end else begin
          cur_col_nxt = cur_col_r + CUR_W'(1);
        end
      end
    end

    // End of a clear or of a scroll; the fresh bottom row is the old top row
    if (cmd.fin_commit) begin
      cur_col_nxt = '0;
      if (is_clear) begin
        cur_line_nxt = '0;
      end else begin
        top_nxt      = top_inc;
        cur_line_nxt = ROW_W'(ROWS - 1);
        if (printable) begin
          we_char     = 1'b1;
          we_color    = 1'b1;
          waddr       = {top_r, {COL_W{1'b0}}};
          wchar       = item_r.char_code;
          wcolor      = item_r.color;
          cur_col_nxt = CUR_W'(1);
        end
      end
    end
  end

  // Result beat
  always_comb begin
    out_nxt = out_r;
    if (cmd.exec_commit || cmd.read_commit || cmd.fin_commit) begin
      out_nxt.cell_char  = (cmd.read_commit && rd_in_range) ? rchar : 8'd0;
      out_nxt.cell_color = (cmd.read_commit && rd_in_range) ? rcolor : 24'd0;
      out_nxt.cursor_col = 7'(cur_col_nxt);
      out_nxt.cursor_row = 5'(cur_line_nxt);
    end
  end

  // Sweep counter: column first, row only for whole-grid sweeps
  always_comb begin
    srow_nxt = srow_r;
    scol_nxt = scol_r;
    if (sweep_step) begin
      if (row_end) begin
        scol_nxt = '0;
        if (!cmd.scroll_step) begin
          srow_nxt = (srow_r == ROW_W'(ROWS - 1)) ? '0 : srow_r + ROW_W'(1);
        end
      end else begin
        scol_nxt = scol_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r      <= '0;
      cur_col_r  <= '0;
      cur_line_r <= '0;
      srow_r     <= '0;
      scol_r     <= '0;
    end else begin
      top_r      <= top_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_line_r <= cur_line_nxt;
      srow_r     <= srow_nxt;
      scol_r     <= scol_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_data = out_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_col_r <= CUR_W'(COLUMNS))
    else $error("cursor column past the row width");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_line_r <= ROW_W'(ROWS - 1))
    else $error("cursor line past the last row");

  a_scroll_top: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_commit && !is_clear |=> top_r != $past(top_r))
    else $error("scroll finished without moving the ring offset");

endmodule

@@ src/tcw_ctrl.sv @@
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tcw_pkg::tcw_status_t status,
  output tcw_pkg::tcw_cmd_t    cmd
);
  import tcw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, load_out;

  // Output register can take a beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (status.all_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.is_read) begin
          state_nxt = ST_READ;
        end else if (status.is_clear) begin
          state_nxt = ST_CLEAR;
        end else if (status.need_scroll) begin
          state_nxt = ST_SCROLL;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (status.all_end) state_nxt = ST_FIN;
      end
      ST_SCROLL: begin
        if (status.row_end) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_INIT:   cmd.init_step = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.take_in = in_valid;
      end
      ST_EXEC: begin
        cmd.exec_commit = !status.is_read && !status.is_clear &&
                          !status.need_scroll && out_free;
      end
      ST_READ:   cmd.read_commit = out_free;
      ST_CLEAR:  cmd.clear_step  = 1'b1;
      ST_SCROLL: cmd.scroll_step = 1'b1;
      ST_FIN:    cmd.fin_commit  = out_free;
      default:   cmd = '0;
    endcase
  end

  assign load_out      = cmd.exec_commit || cmd.read_commit || cmd.fin_commit;
  assign out_valid_nxt = load_out || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !(out_valid_r && out_stall))
    else $error("result loaded over a beat still waiting");

  a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_in |=> state_r == ST_EXEC)
    else $error("accepted item not executed next cycle");

endmodule

@@ src/text_console_cell_writer_core.sv @@
// Text console cell grid with cursor, 30 rows by 100 columns of char + RGB.
// Input channel in_valid/in_stall/in_data carries one command beat: put a
// byte (with newline, return, backspace and tab handling), read one visible
// cell, or clear the screen. Every command gives exactly one result beat on
// out_valid/out_stall/out_data: the read cell (zero for other commands) and
// the cursor after the command.
// Steps per command, up to the result in the output register:
//   put without scroll, and unused action codes: the next item is taken
//   only after this one is done (one write to the cell memories per character);
//   read: registered memory read;
//   put that scrolls: the new bottom row is blanked one cell a cycle through
//   the memory write port;
//   clear: every character cell is blanked one a cycle.
// After reset the block sweeps both cell memories (spaces in white), holding
// in_stall high, then takes commands.
// The result sits in an output register: while the receiver stalls, the next
// command is accepted and executed up to the point where its result would be
// loaded, then waits there.
module text_console_cell_writer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
